// ===== rtl/gbn_pkg.sv =====
// Shared types, constants and register codes for the Go-Back-N link endpoint.
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

	localparam int SEQ_W  = 16;
	localparam int CTR_W  = SEQ_W + 1;   // next and acked sequence range
	localparam int CMP_W  = SEQ_W + 3;   // signed compare width

	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 56;
	localparam int M_DATA_W   = 56;

	// Event kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_START   = 3'd0,
		KIND_SEND    = 3'd1,
		KIND_TIMEOUT = 3'd2,
		KIND_RX      = 3'd3,
		KIND_STOP    = 3'd4
	} kind_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT    = 8'd3;

	// Reset values of the configuration registers
	localparam logic [7:0]       WINDOW_SIZE_RST   = 8'd4;
	localparam logic [SEQ_W-1:0] TOTAL_FRAMES_RST  = 16'd1;
	localparam logic [3:0]       TIMEOUT_LIMIT_RST = 4'd8;
	localparam logic [7:0]       IDLE_LIMIT_RST    = 8'd100;

	typedef struct packed {
		logic [7:0]       window_size;
		logic [SEQ_W-1:0] total_frames;
		logic [3:0]       timeout_limit;
		logic [7:0]       idle_limit;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              rx_crc_ok;
		logic              rx_has_data;
		logic [SEQ_W-1:0]  rx_seq;
		logic              rx_has_ack;
		logic [SEQ_W-1:0]  rx_ack;
		logic [SEQ_W-1:0]  rx_frame_count;
	} item_t;

	typedef struct packed {
		logic             tx_is_header;
		logic             tx_has_data;
		logic [SEQ_W-1:0] tx_seq;
		logic             tx_has_ack;
		logic [SEQ_W-1:0] tx_ack;
		logic             deliver_valid;
		logic [SEQ_W-1:0] deliver_seq;
		logic             sending;
		logic             receiving;
		logic             gave_up;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/go_back_n_link_endpoint.sv =====
// Top level: input stage, event core, result register and configuration port.
// An accepted word waits in the input register; the core processes it there and
// loads the result register, which drives m_tvalid until the word is taken.
// Throughput: one event per cycle while m_tready stays high; while a result waits
// on m_tready the input register holds one more word, then s_tready drops.
// Reset (arst_n low, asynchronous): both sides idle, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_link_endpoint (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// rx_crc_ok, rx_has_data, rx_seq[15:0], rx_has_ack, rx_ack[15:0],
	// rx_frame_count[15:0], zero fill
	input  wire  [gbn_pkg::S_DATA_W-1:0]       s_tdata,
	// kind[2:0]
	input  wire  [gbn_pkg::KIND_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// tx_is_header, tx_has_data, tx_seq[15:0], tx_has_ack, tx_ack[15:0],
	// deliver_valid, deliver_seq[15:0], sending, receiving, gave_up, zero fill
	output logic [gbn_pkg::M_DATA_W-1:0]       m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [gbn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int RES_W = $bits(gbn_pkg::result_t);

	gbn_pkg::cfg_t    cfg;
	gbn_pkg::item_t   item_s1;
	gbn_pkg::result_t res, res_q;
	logic             valid_s1;
	logic             advance;
	logic             emit;
	logic             out_valid_q;

	assign cfg_ready = 1'b1;

	gbn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind           <= s_tuser;
			item_s1.rx_crc_ok      <= s_tdata[0];
			item_s1.rx_has_data    <= s_tdata[1];
			item_s1.rx_seq         <= s_tdata[17:2];
			item_s1.rx_has_ack     <= s_tdata[18];
			item_s1.rx_ack         <= s_tdata[34:19];
			item_s1.rx_frame_count <= s_tdata[50:35];
		end
	end

	gbn_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// Result register: drop on drain, load when the event emits a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	// Pack the result word, first field in the lowest bit
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		{(gbn_pkg::M_DATA_W - RES_W){1'b0}},
		res_q.gave_up,
		res_q.receiving,
		res_q.sending,
		res_q.deliver_seq,
		res_q.deliver_valid,
		res_q.tx_ack,
		res_q.tx_has_ack,
		res_q.tx_seq,
		res_q.tx_has_data,
		res_q.tx_is_header
	};

endmodule
`default_nettype wire

// ===== rtl/gbn_cfg.sv =====
// Configuration registers of the Go-Back-N link endpoint.
`timescale 1ns / 1ps
`default_nettype none
module gbn_cfg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	input  wire [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [gbn_pkg::CFG_DATA_W-1:0]    cfg_data,
	output gbn_pkg::cfg_t                    cfg
);

	gbn_pkg::cfg_t cfg_q;

	// Decode the index and latch the written field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= gbn_pkg::WINDOW_SIZE_RST;
			cfg_q.total_frames  <= gbn_pkg::TOTAL_FRAMES_RST;
			cfg_q.timeout_limit <= gbn_pkg::TIMEOUT_LIMIT_RST;
			cfg_q.idle_limit    <= gbn_pkg::IDLE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gbn_pkg::REG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data[7:0];
				gbn_pkg::REG_TOTAL_FRAMES:  cfg_q.total_frames  <= cfg_data[15:0];
				gbn_pkg::REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data[3:0];
				gbn_pkg::REG_IDLE_LIMIT:    cfg_q.idle_limit    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/gbn_core.sv =====
// Sender and receiver state, updated from each event by combinational next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module gbn_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              fire,
	input  gbn_pkg::item_t   item,
	input  gbn_pkg::cfg_t    cfg,
	output logic             emit,
	output gbn_pkg::result_t res
);

	localparam int SW = gbn_pkg::SEQ_W;
	localparam int CW = gbn_pkg::CTR_W;
	localparam int XW = gbn_pkg::CMP_W;

	logic [CW-1:0] next_seq_q, next_seq_d;
	logic [CW-1:0] acked_q, acked_d;      // two's complement, reset to minus one
	logic [CW-1:0] snap_q, snap_d;
	logic [3:0]    tmo_q, tmo_d;
	logic [7:0]    idle_q, idle_d;
	logic          send_q, send_d;
	logic          recv_q, recv_d;
	logic [SW-1:0] rlast_q, rlast_d;
	logic [SW-1:0] rtotal_q, rtotal_d;

	logic signed [XW-1:0] total_x, acked_x, next_x, win_x, rack_x, span_x;
	logic                 all_acked, in_window, unsent, ack_fwd;
	logic [CW-1:0]        acked_inc;
	logic [SW-1:0]        rlast_inc;

	// Sign-extended compares over the sequence range
	always_comb begin
		total_x   = $signed({3'b000, cfg.total_frames});
		acked_x   = $signed({{2{acked_q[CW-1]}}, acked_q});
		next_x    = $signed({2'b00, next_seq_q});
		win_x     = $signed({{(XW-8){1'b0}}, cfg.window_size});
		rack_x    = $signed({3'b000, item.rx_ack});
		span_x    = next_x - acked_x;
		all_acked = total_x <= acked_x;
		in_window = span_x <= win_x;
		unsent    = next_seq_q <= {1'b0, cfg.total_frames};
		ack_fwd   = rack_x > acked_x;
		acked_inc = acked_q + {{(CW-1){1'b0}}, 1'b1};
		rlast_inc = rlast_q + {{(SW-1){1'b0}}, 1'b1};
	end

	// Next state and result for one event
	always_comb begin
		next_seq_d = next_seq_q;
		acked_d    = acked_q;
		snap_d     = snap_q;
		tmo_d      = tmo_q;
		idle_d     = idle_q;
		send_d     = send_q;
		recv_d     = recv_q;
		rlast_d    = rlast_q;
		rtotal_d   = rtotal_q;
		res        = '0;
		emit       = 1'b1;
		unique case (gbn_pkg::kind_t'(item.kind))
			gbn_pkg::KIND_START: begin
				next_seq_d       = {{(CW-1){1'b0}}, 1'b1};
				acked_d          = '1;
				snap_d           = '0;
				tmo_d            = '0;
				idle_d           = '0;
				send_d           = 1'b1;
				res.tx_is_header = 1'b1;
				res.tx_has_data  = 1'b1;
			end
			gbn_pkg::KIND_SEND: begin
				if (!send_q && !recv_q) begin
					emit = 1'b0;
				end
				if (recv_q) begin
					res.tx_has_ack = 1'b1;
					res.tx_ack     = rlast_q;
				end
				if (send_q) begin
					if (all_acked) begin
						send_d = 1'b0;
					end else if (unsent && in_window) begin
						idle_d           = '0;
						res.tx_has_data  = 1'b1;
						res.tx_seq       = next_seq_q[SW-1:0];
						res.tx_is_header = (next_seq_q == '0);
						next_seq_d       = next_seq_q + {{(CW-1){1'b0}}, 1'b1};
					end else if (unsent) begin
						if (idle_q >= cfg.idle_limit) begin
							send_d      = 1'b0;
							idle_d      = '0;
							res.gave_up = 1'b1;
						end else begin
							idle_d = idle_q + 8'd1;
						end
					end
				end
			end
			gbn_pkg::KIND_TIMEOUT: begin
				if (send_q) begin
					if (snap_q == acked_q) begin
						// no progress: rewind to the oldest unacknowledged frame
						next_seq_d = acked_inc;
						if (tmo_q >= cfg.timeout_limit) begin
							send_d      = 1'b0;
							recv_d      = 1'b0;
							tmo_d       = '0;
							res.gave_up = 1'b1;
						end else begin
							tmo_d = tmo_q + 4'd1;
						end
					end else begin
						tmo_d  = '0;
						snap_d = acked_q;
					end
				end
			end
			gbn_pkg::KIND_RX: begin
				if (item.rx_crc_ok) begin
					if (item.rx_has_data && item.rx_seq == '0) begin
						// header: answer with ack zero if fully idle
						if (!send_q && !recv_q) begin
							res.tx_has_ack = 1'b1;
						end
						rlast_d  = '0;
						rtotal_d = item.rx_frame_count;
						recv_d   = (item.rx_frame_count != '0);
					end else if (item.rx_has_data && recv_q) begin
						if (item.rx_seq == rlast_inc) begin
							rlast_d           = item.rx_seq;
							res.deliver_valid = 1'b1;
							res.deliver_seq   = item.rx_seq;
							recv_d            = (item.rx_seq != rtotal_q);
						end
					end
					if (send_q && item.rx_has_ack && ack_fwd) begin
						acked_d = {1'b0, item.rx_ack};
					end
				end
			end
			gbn_pkg::KIND_STOP: begin
				send_d = 1'b0;
				recv_d = 1'b0;
			end
			default: ;
		endcase
		res.sending   = send_d;
		res.receiving = recv_d;
	end

	// Commit state when an event is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			acked_q    <= '1;
			snap_q     <= '0;
			tmo_q      <= '0;
			idle_q     <= '0;
			send_q     <= 1'b0;
			recv_q     <= 1'b0;
			rlast_q    <= '0;
			rtotal_q   <= '0;
		end else if (fire) begin
			next_seq_q <= next_seq_d;
			acked_q    <= acked_d;
			snap_q     <= snap_d;
			tmo_q      <= tmo_d;
			idle_q     <= idle_d;
			send_q     <= send_d;
			recv_q     <= recv_d;
			rlast_q    <= rlast_d;
			rtotal_q   <= rtotal_d;
		end
	end

endmodule
`default_nettype wire

// ===== test/gbn_link_checker.sv =====
// Checker: predicts each frame word of the Go-Back-N endpoint and compares it with the output.
`timescale 1ns / 1ps
module gbn_link_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	input  wire                           s_tready,
	input  wire [gbn_pkg::S_DATA_W-1:0]   s_tdata,
	input  wire [gbn_pkg::KIND_W-1:0]     s_tuser,
	input  wire                           m_tvalid,
	input  wire                           m_tready,
	input  wire [gbn_pkg::M_DATA_W-1:0]   m_tdata,
	input  wire                           cfg_valid,
	input  wire                           cfg_ready,
	input  wire [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                            fail_count,
	output int                            pending
);

	// Shadow copy of the endpoint registers and link state
	gbn_pkg::cfg_t                    link_cfg;
	logic [gbn_pkg::CTR_W-1:0]        next_seq;     // 0..65536
	logic signed [gbn_pkg::CTR_W-1:0] acked_seq;    // -1..65535
	logic signed [gbn_pkg::CTR_W-1:0] acked_snap;
	logic [3:0]                       tmo_count;
	logic [7:0]                       idle_count;
	logic                             send_on;
	logic                             recv_on;
	logic [gbn_pkg::SEQ_W-1:0]        recv_last;
	logic [gbn_pkg::SEQ_W-1:0]        recv_total;

	// Frame words still owed by the endpoint, oldest first
	gbn_pkg::result_t frame_q[$];

	task automatic clear_link();
		link_cfg.window_size   = gbn_pkg::WINDOW_SIZE_RST;
		link_cfg.total_frames  = gbn_pkg::TOTAL_FRAMES_RST;
		link_cfg.timeout_limit = gbn_pkg::TIMEOUT_LIMIT_RST;
		link_cfg.idle_limit    = gbn_pkg::IDLE_LIMIT_RST;
		next_seq   = '0;
		acked_seq  = '1;
		acked_snap = '0;
		tmo_count  = '0;
		idle_count = '0;
		send_on    = 1'b0;
		recv_on    = 1'b0;
		recv_last  = '0;
		recv_total = '0;
	endtask

	// Advance the link by one event; emits is low when no frame word follows
	task automatic step_link(input gbn_pkg::item_t it, output logic emits,
			output gbn_pkg::result_t res);
		logic unsent;
		res   = '0;
		emits = 1'b1;
		case (it.kind)
			gbn_pkg::KIND_START: begin
				next_seq   = gbn_pkg::CTR_W'(1);
				acked_seq  = '1;
				acked_snap = '0;
				tmo_count  = '0;
				idle_count = '0;
				send_on    = 1'b1;
				res.tx_is_header = 1'b1;
				res.tx_has_data  = 1'b1;
			end
			gbn_pkg::KIND_SEND: begin
				if (!send_on && !recv_on) begin
					emits = 1'b0;
				end else begin
					if (recv_on) begin
						res.tx_has_ack = 1'b1;
						res.tx_ack     = recv_last;
					end
					if (send_on) begin
						unsent = (int'(next_seq) <= int'(link_cfg.total_frames));
						if (int'(link_cfg.total_frames) <= int'(acked_seq)) begin
							// last frame acknowledged: sender is done
							send_on = 1'b0;
						end else if (unsent && int'(next_seq) - int'(acked_seq)
								<= int'(link_cfg.window_size)) begin
							idle_count      = '0;
							res.tx_has_data = 1'b1;
							res.tx_seq      = next_seq[gbn_pkg::SEQ_W-1:0];
							if (next_seq == '0)
								res.tx_is_header = 1'b1;
							next_seq = next_seq + 1'b1;
						end else if (unsent) begin
							// window full: count ticks, give up past the limit
							if (idle_count >= link_cfg.idle_limit) begin
								send_on     = 1'b0;
								idle_count  = '0;
								res.gave_up = 1'b1;
							end else begin
								idle_count = idle_count + 1'b1;
							end
						end
					end
				end
			end
			gbn_pkg::KIND_TIMEOUT: begin
				if (send_on) begin
					if (acked_snap == acked_seq) begin
						// no progress: go back to the oldest unacked frame
						next_seq = gbn_pkg::CTR_W'(int'(acked_seq) + 1);
						if (tmo_count >= link_cfg.timeout_limit) begin
							send_on     = 1'b0;
							recv_on     = 1'b0;
							tmo_count   = '0;
							res.gave_up = 1'b1;
						end else begin
							tmo_count = tmo_count + 1'b1;
						end
					end else begin
						tmo_count  = '0;
						acked_snap = acked_seq;
					end
				end
			end
			gbn_pkg::KIND_RX: begin
				if (it.rx_crc_ok) begin
					if (it.rx_has_data && it.rx_seq == '0) begin
						// header: (re)open the receiver
						if (!send_on && !recv_on) begin
							res.tx_has_ack = 1'b1;
							res.tx_ack     = '0;
						end
						recv_on    = 1'b1;
						recv_last  = '0;
						recv_total = it.rx_frame_count;
						if (recv_last == recv_total)
							recv_on = 1'b0;
					end else if (it.rx_has_data && recv_on) begin
						if (it.rx_seq == gbn_pkg::SEQ_W'(recv_last + 1'b1)) begin
							recv_last         = it.rx_seq;
							res.deliver_valid = 1'b1;
							res.deliver_seq   = it.rx_seq;
							if (recv_last == recv_total)
								recv_on = 1'b0;
						end
					end
					if (send_on && it.rx_has_ack && int'(it.rx_ack) > int'(acked_seq))
						acked_seq = gbn_pkg::CTR_W'(it.rx_ack);
				end
			end
			gbn_pkg::KIND_STOP: begin
				send_on = 1'b0;
				recv_on = 1'b0;
			end
			default: begin
			end
		endcase
		res.sending   = send_on;
		res.receiving = recv_on;
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		gbn_pkg::item_t   it;
		gbn_pkg::result_t want;
		gbn_pkg::result_t got;
		logic             emits;
		if (!arst_n) begin
			clear_link();
			frame_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// drain the output side first so a new item never pairs with an old word
			if (m_tvalid && m_tready) begin
				got.tx_is_header  = m_tdata[0];
				got.tx_has_data   = m_tdata[1];
				got.tx_seq        = m_tdata[17:2];
				got.tx_has_ack    = m_tdata[18];
				got.tx_ack        = m_tdata[34:19];
				got.deliver_valid = m_tdata[35];
				got.deliver_seq   = m_tdata[51:36];
				got.sending       = m_tdata[52];
				got.receiving     = m_tdata[53];
				got.gave_up       = m_tdata[54];
				if (frame_q.size() == 0) begin
					$error("unexpected frame word %h", m_tdata);
					fail_count++;
				end else begin
					want = frame_q.pop_front();
					check_field("tx_is_header", want.tx_is_header, got.tx_is_header);
					check_field("tx_has_data", want.tx_has_data, got.tx_has_data);
					check_field("tx_seq", want.tx_seq, got.tx_seq);
					check_field("tx_has_ack", want.tx_has_ack, got.tx_has_ack);
					check_field("tx_ack", want.tx_ack, got.tx_ack);
					check_field("deliver_valid", want.deliver_valid, got.deliver_valid);
					check_field("deliver_seq", want.deliver_seq, got.deliver_seq);
					check_field("sending", want.sending, got.sending);
					check_field("receiving", want.receiving, got.receiving);
					check_field("gave_up", want.gave_up, got.gave_up);
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gbn_pkg::REG_WINDOW_SIZE:
						link_cfg.window_size   = cfg_data[7:0];
					gbn_pkg::REG_TOTAL_FRAMES:
						link_cfg.total_frames  = cfg_data[gbn_pkg::SEQ_W-1:0];
					gbn_pkg::REG_TIMEOUT_LIMIT:
						link_cfg.timeout_limit = cfg_data[3:0];
					gbn_pkg::REG_IDLE_LIMIT:
						link_cfg.idle_limit    = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			// new event
			if (s_tvalid && s_tready) begin
				it.kind           = s_tuser;
				it.rx_crc_ok      = s_tdata[0];
				it.rx_has_data    = s_tdata[1];
				it.rx_seq         = s_tdata[17:2];
				it.rx_has_ack     = s_tdata[18];
				it.rx_ack         = s_tdata[34:19];
				it.rx_frame_count = s_tdata[50:35];
				step_link(it, emits, want);
				if (emits)
					frame_q.push_back(want);
			end
			pending <= frame_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top: clock, reset, event stimulus and verdict for the Go-Back-N link endpoint.
`timescale 1ns / 1ps
module tb_top;

	localparam int UNUSED_KIND_LO = 5;
	localparam int UNUSED_KIND_HI = 7;
	localparam int WORD_TARGET    = 1100;
	localparam int GAP_MAX        = 19;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HEADER_SEQ     = 0;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [gbn_pkg::S_DATA_W-1:0]   s_tdata;
	logic [gbn_pkg::KIND_W-1:0]     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [gbn_pkg::M_DATA_W-1:0]   m_tdata;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             fail_count;
	int                             pending;

	// idling switches, per phase
	bit src_gaps_on;
	bit sink_gaps_on;
	int word_count;

	// partner view of the link
	logic [gbn_pkg::SEQ_W-1:0] peer_next;
	logic [gbn_pkg::SEQ_W-1:0] peer_total;
	int                        peer_ack;
	int                        sent_est;

	go_back_n_link_endpoint dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gbn_link_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin : watchdog
		#20_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Output side: stall a random number of cycles after each accepted word
	initial begin : frame_sink
		int hold;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				hold = sink_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
				if (hold > 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (hold > 0)
					hold--;
				if (hold == 0)
					m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [gbn_pkg::SEQ_W-1:0] rnd16();
		return gbn_pkg::SEQ_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// Cumulative ack as the partner would send it; sometimes a wild value
	function automatic logic [gbn_pkg::SEQ_W-1:0] next_ack();
		int hi;
		hi = (sent_est > 65535) ? 65535 : sent_est;
		if ($urandom_range(0, 19) == 0)
			return rnd16();
		if (hi > peer_ack)
			peer_ack = $urandom_range(peer_ack, hi);
		return gbn_pkg::SEQ_W'(peer_ack);
	endfunction

	// Offer one event word after a random gap, hold until taken
	task automatic put_word(input logic [gbn_pkg::KIND_W-1:0] k, input logic crc_ok,
			input logic has_data, input logic [gbn_pkg::SEQ_W-1:0] seq,
			input logic has_ack, input logic [gbn_pkg::SEQ_W-1:0] ack,
			input logic [gbn_pkg::SEQ_W-1:0] count);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {5'b0, count, ack, has_ack, seq, has_data, crc_ok};
		do @(posedge clk); while (!s_tready);
		if (k < UNUSED_KIND_LO)
			word_count++;
	endtask

	// Hold off until every frame word is back, then let the core settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gbn_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= gbn_pkg::CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input int win, input int tot, input int tmo, input int idl);
		write_reg(gbn_pkg::REG_WINDOW_SIZE, win);
		write_reg(gbn_pkg::REG_TOTAL_FRAMES, tot);
		write_reg(gbn_pkg::REG_TIMEOUT_LIMIT, tmo);
		write_reg(gbn_pkg::REG_IDLE_LIMIT, idl);
		cfg_valid <= 1'b0;
	endtask

	task automatic start_sender();
		put_word(gbn_pkg::KIND_START, coin(), coin(), rnd16(), coin(), rnd16(), rnd16());
		peer_ack = 0;
		sent_est = 0;
	endtask

	task automatic send_header();
		peer_total = gbn_pkg::SEQ_W'($urandom_range(0, 12));
		peer_next  = 16'd1;
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, gbn_pkg::SEQ_W'(HEADER_SEQ), coin(),
			next_ack(), peer_total);
	endtask

	// Mostly well-formed partner traffic with some broken and random frames
	task automatic run_traffic(input int n_words);
		int                        n;
		int                        r;
		logic                      crc;
		logic [gbn_pkg::SEQ_W-1:0] seq;
		for (n = 0; n < n_words; n++) begin
			r   = $urandom_range(0, 99);
			crc = ($urandom_range(0, 9) != 0);
			if (r < 40) begin
				sent_est++;
				put_word(gbn_pkg::KIND_SEND, coin(), coin(), rnd16(), coin(), rnd16(),
					rnd16());
			end else if (r < 58) begin
				case ($urandom_range(0, 9))
					0: seq = peer_next + 16'd1;
					1: seq = peer_next - 16'd1;
					2: seq = rnd16();
					default: seq = peer_next;
				endcase
				put_word(gbn_pkg::KIND_RX, crc, 1'b1, seq, coin(), next_ack(), rnd16());
				if (crc && seq == gbn_pkg::SEQ_W'(HEADER_SEQ))
					peer_next = 16'd1;
				else if (crc && seq == peer_next)
					peer_next++;
			end else if (r < 68) begin
				put_word(gbn_pkg::KIND_RX, crc, 1'b0, rnd16(), 1'b1, next_ack(), rnd16());
			end else if (r < 80) begin
				put_word(gbn_pkg::KIND_TIMEOUT, coin(), coin(), rnd16(), coin(), rnd16(),
					rnd16());
			end else if (r < 83) begin
				send_header();
			end else if (r < 86) begin
				start_sender();
			end else if (r < 88) begin
				put_word(gbn_pkg::KIND_STOP, coin(), coin(), rnd16(), coin(), rnd16(),
					rnd16());
			end else if (r < 90) begin
				put_word(gbn_pkg::KIND_W'($urandom_range(UNUSED_KIND_LO, UNUSED_KIND_HI)),
					coin(), coin(), rnd16(), coin(), rnd16(), rnd16());
			end else begin
				put_word(gbn_pkg::KIND_RX, coin(), coin(), rnd16(), coin(), rnd16(), rnd16());
			end
		end
	endtask

	// One setting of the registers, then sessions until enough words went in
	task automatic run_phase(input int win, input int tot, input int tmo, input int idl,
			input int n_words);
		int target;
		drain();
		load_settings(win, tot, tmo, idl);
		src_gaps_on  = ($urandom_range(0, 3) != 0);
		sink_gaps_on = ($urandom_range(0, 3) != 0);
		target = word_count + n_words;
		while (word_count < target) begin
			if ($urandom_range(0, 9) != 0)
				start_sender();
			if ($urandom_range(0, 4) != 0)
				send_header();
			run_traffic($urandom_range(15, 50));
		end
	endtask

	// Directed events on the reset settings: window 4, one frame
	task automatic run_directed();
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_TIMEOUT, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		// bad check on a header, then data while the receiver is idle
		put_word(gbn_pkg::KIND_RX, 1'b0, 1'b1, 16'd0, 1'b1, 16'd3, 16'd5);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd7, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_W'(UNUSED_KIND_LO), 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF,
			16'hFFFF);
		put_word(gbn_pkg::KIND_W'(UNUSED_KIND_LO + 1), 1'b0, 1'b0, 16'd0, 1'b0, 16'd0,
			16'd0);
		put_word(gbn_pkg::KIND_W'(UNUSED_KIND_HI), 1'b1, 1'b0, 16'h5555, 1'b1, 16'hAAAA,
			16'h1234);
		// header announcing zero frames while idle: ack-only, receiver done at once
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd0, 1'b1, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_START, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		// snapshot, then no progress: rewind to the header
		put_word(gbn_pkg::KIND_TIMEOUT, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_TIMEOUT, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd0, 1'b0, 16'd0, 16'd3);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd1, 1'b1, 16'd1, 16'hFFFF);
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
		// out of order, then in order to completion
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd3, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd2, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'd3, 1'b0, 16'd0, 16'd0);
		put_word(gbn_pkg::KIND_STOP, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		// ack beyond anything sent ends the sender on the next tick
		put_word(gbn_pkg::KIND_START, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		put_word(gbn_pkg::KIND_RX, 1'b1, 1'b0, 16'd0, 1'b1, 16'hFFFF, 16'd0);
		put_word(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
	endtask

	initial begin : stimulus
		int win;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		word_count = 0;
		peer_next  = 16'd1;
		peer_total = '0;
		peer_ack   = 0;
		sent_est   = 0;
		src_gaps_on  = 1'b1;
		sink_gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		// smallest window, widest settings, zero limits, then a mid point
		run_phase(1, 3, 1, 1, 120);
		run_phase(255, 65535, 15, 255, 120);
		run_phase(2, 8, 0, 0, 100);
		run_phase(3, 12, 2, 4, 120);
		while (word_count < WORD_TARGET) begin
			win = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
			run_phase(win, $urandom_range(1, 16), $urandom_range(1, 15),
				$urandom_range(1, 20), 150);
		end
		drain();

		if (fail_count == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
